>>> src/htok_pkg.sv
// Shared types and constants of the HTTP request tokenizer.
// Used by every module of the block; depends on nothing.
package htok_pkg;

    // Token classes carried in token_class
    localparam logic [2:0] CL_METHOD  = 3'd0;
    localparam logic [2:0] CL_PATH    = 3'd1;
    localparam logic [2:0] CL_VERSION = 3'd2;
    localparam logic [2:0] CL_NAME    = 3'd3;
    localparam logic [2:0] CL_VALUE   = 3'd4;
    localparam logic [2:0] CL_BODY    = 3'd5;
    localparam logic [2:0] CL_SEP     = 3'd6;

    // Request status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD     = 2'd1;
    localparam logic [1:0] ST_VERSION = 2'd2;
    localparam logic [1:0] ST_PARSING = 2'd3;

    // Special characters
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Length of the only accepted version string
    localparam int VERSION_LEN = 8;
    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Character i of "HTTP/1.1"
    function automatic logic [7:0] version_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0: c = 8'h48; // H
            3'd1: c = 8'h54; // T
            3'd2: c = 8'h54; // T
            3'd3: c = 8'h50; // P
            3'd4: c = 8'h2F; // /
            3'd5: c = 8'h31; // 1
            3'd6: c = 8'h2E; // .
            default: c = 8'h31; // 1
        endcase
        return c;
    endfunction

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } htok_in_t;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [2:0]  token_class;
        logic        pair_start;
        logic        done_res;
        logic [1:0]  status;
        logic [15:0] body_length;
    } htok_out_t;

    // Byte classification done by the front
    typedef struct packed {
        logic                   is_cr;
        logic                   is_lf;
        logic                   is_colon;
        logic                   is_space;
        logic                   is_zero;
        logic [VERSION_LEN-1:0] ver_match;
    } htok_flags_t;

    typedef struct packed {
        htok_in_t    item;
        htok_flags_t flags;
    } htok_entry_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } htok_q_status_t;

endpackage

>>> src/htok_front.sv
// Front of the tokenizer: accepts input transactions and classifies each byte.
// Depends on htok_pkg; feeds htok_queue.
module htok_front (
    input  logic                    s_valid,
    output logic                    s_ready,
    input  htok_pkg::htok_in_t      s_data,
    input  htok_pkg::htok_q_status_t q_status,
    output logic                    push,
    output htok_pkg::htok_entry_t   push_entry
);

    // Accept while the queue has room
    assign s_ready = !q_status.full;
    assign push    = s_valid && !q_status.full;

    // Character compares
    always_comb begin
        push_entry.item           = s_data;
        push_entry.flags.is_cr    = (s_data.data_byte == htok_pkg::CH_CR);
        push_entry.flags.is_lf    = (s_data.data_byte == htok_pkg::CH_LF);
        push_entry.flags.is_colon = (s_data.data_byte == htok_pkg::CH_COLON);
        push_entry.flags.is_space = (s_data.data_byte == htok_pkg::CH_SPACE);
        push_entry.flags.is_zero  = (s_data.data_byte == htok_pkg::CH_NUL);
        for (int i = 0; i < htok_pkg::VERSION_LEN; i++) begin
            push_entry.flags.ver_match[i] =
                (s_data.data_byte == htok_pkg::version_char(3'(i)));
        end
    end

endmodule

>>> src/htok_queue.sv
// Short FIFO of classified bytes between front and back.
// Depends on htok_pkg.
module htok_queue (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  htok_pkg::htok_entry_t    push_entry,
    input  logic                     pop,
    output htok_pkg::htok_entry_t    head_entry,
    output htok_pkg::htok_q_status_t q_status
);

    localparam int PTR_W = (htok_pkg::QUEUE_DEPTH > 1) ? $clog2(htok_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(htok_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(htok_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(htok_pkg::QUEUE_DEPTH - 1);

    htok_pkg::htok_entry_t mem_reg [htok_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign q_status.full  = (count_reg == DEPTH_C);
    assign q_status.empty = (count_reg == '0);
    assign head_entry     = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_C) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_C) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> src/htok_back.sv
// Back of the tokenizer: request parser state machine and output register.
// Depends on htok_pkg; consumes entries from htok_queue.
module htok_back #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  htok_pkg::htok_entry_t    head_entry,
    input  htok_pkg::htok_q_status_t q_status,
    output logic                     pop,
    output logic                     m_valid,
    input  logic                     m_ready,
    output htok_pkg::htok_out_t      m_data
);

    localparam int CNT_W = (LENGTH_BITS < 16) ? LENGTH_BITS : 16;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [9:0] {
        PH_METHOD     = 10'b00_0000_0001,
        PH_PATH       = 10'b00_0000_0010,
        PH_VERSION    = 10'b00_0000_0100,
        PH_LINE_START = 10'b00_0000_1000,
        PH_LINE_CR    = 10'b00_0001_0000,
        PH_NAME       = 10'b00_0010_0000,
        PH_SKIP       = 10'b00_0100_0000,
        PH_VALUE      = 10'b00_1000_0000,
        PH_BODY       = 10'b01_0000_0000,
        PH_ENDED      = 10'b10_0000_0000
    } htok_phase_t;

    htok_phase_t      phase_reg, phase_next;
    logic [3:0]       ver_idx_reg, ver_idx_next;
    logic             mismatch_reg, mismatch_next;
    logic             pcr_reg, pcr_next;
    logic             colon_reg, colon_next;
    logic [1:0]       err_reg, err_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg;
    htok_pkg::htok_out_t out_reg, out_next;

    htok_pkg::htok_flags_t fl;
    logic [7:0]  b;
    logic        last;
    logic [2:0]  cls;
    logic        pstart;
    logic        lb_run;
    htok_phase_t lb_phase;
    logic        lb_colon;
    logic [1:0]  final_st;

    assign fl      = head_entry.flags;
    assign b       = head_entry.item.data_byte;
    assign last    = head_entry.item.is_last;
    assign pop     = !q_status.empty && (!out_valid_reg || m_ready);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Per-byte parse step
    always_comb begin
        phase_next    = phase_reg;
        ver_idx_next  = ver_idx_reg;
        mismatch_next = mismatch_reg;
        pcr_next      = pcr_reg;
        colon_next    = colon_reg;
        err_next      = err_reg;
        count_next    = count_reg;
        cls           = htok_pkg::CL_SEP;
        pstart        = 1'b0;
        lb_run        = 1'b0;
        lb_phase      = phase_reg;
        lb_colon      = colon_reg;
        final_st      = err_reg;
        out_next      = out_reg;

        if (phase_reg != PH_ENDED && fl.is_zero) begin
            // zero byte ends the data
            phase_next = PH_ENDED;
            err_next   = (phase_reg == PH_BODY) ? htok_pkg::ST_OK : htok_pkg::ST_BAD;
        end else begin
            case (phase_reg)
                PH_METHOD, PH_PATH: begin
                    if (fl.is_lf) begin
                        phase_next = PH_ENDED;
                        err_next   = htok_pkg::ST_BAD;
                    end else if (fl.is_space) begin
                        phase_next = (phase_reg == PH_METHOD) ? PH_PATH : PH_VERSION;
                    end else if (!fl.is_cr) begin
                        cls = (phase_reg == PH_METHOD) ? htok_pkg::CL_METHOD
                                                       : htok_pkg::CL_PATH;
                    end
                end
                PH_VERSION: begin
                    if (fl.is_lf) begin
                        pcr_next = 1'b0;
                        if (mismatch_reg || ver_idx_reg != 4'(htok_pkg::VERSION_LEN)) begin
                            phase_next = PH_ENDED;
                            err_next   = htok_pkg::ST_VERSION;
                        end else begin
                            phase_next = PH_LINE_START;
                        end
                    end else if (fl.is_cr) begin
                        if (pcr_reg) begin
                            mismatch_next = 1'b1;
                        end
                        pcr_next = 1'b1;
                    end else begin
                        if (pcr_reg) begin
                            mismatch_next = 1'b1;
                        end
                        pcr_next = 1'b0;
                        if (!ver_idx_reg[3] && fl.ver_match[ver_idx_reg[2:0]]) begin
                            ver_idx_next = ver_idx_reg + 4'd1;
                        end else begin
                            mismatch_next = 1'b1;
                        end
                        cls = htok_pkg::CL_VERSION;
                    end
                end
                PH_LINE_START: begin
                    colon_next = 1'b0;
                    pcr_next   = 1'b0;
                    if (fl.is_cr) begin
                        phase_next = PH_LINE_CR;
                    end else begin
                        pstart   = 1'b1;
                        lb_run   = 1'b1;
                        lb_phase = PH_NAME;
                        lb_colon = 1'b0;
                    end
                end
                PH_LINE_CR: begin
                    if (fl.is_lf) begin
                        phase_next = PH_BODY;
                    end else begin
                        pstart   = 1'b1;
                        lb_run   = 1'b1;
                        lb_phase = PH_NAME;
                    end
                end
                PH_NAME, PH_SKIP, PH_VALUE: begin
                    lb_run = 1'b1;
                end
                PH_BODY: begin
                    if (count_reg != CNT_MAX) begin
                        count_next = count_reg + 1'b1;
                    end
                    cls = htok_pkg::CL_BODY;
                end
                default: begin
                end
            endcase
        end

        // One byte of a header line
        if (lb_run) begin
            phase_next = lb_phase;
            if (fl.is_lf) begin
                pcr_next = 1'b0;
                if (!lb_colon) begin
                    phase_next = PH_ENDED;
                    err_next   = htok_pkg::ST_BAD;
                end else begin
                    phase_next = PH_LINE_START;
                end
            end else if (fl.is_cr) begin
                pcr_next = 1'b1;
                if (lb_phase == PH_SKIP) begin
                    phase_next = PH_VALUE;
                end
            end else begin
                pcr_next = 1'b0;
                if (lb_phase == PH_NAME) begin
                    if (fl.is_colon) begin
                        colon_next = 1'b1;
                        phase_next = PH_SKIP;
                    end else begin
                        cls = htok_pkg::CL_NAME;
                    end
                end else if (lb_phase == PH_SKIP) begin
                    if (!fl.is_space) begin
                        phase_next = PH_VALUE;
                        cls        = htok_pkg::CL_VALUE;
                    end
                end else begin
                    cls = htok_pkg::CL_VALUE;
                end
            end
        end

        // Result item
        out_next.byte_out    = b;
        out_next.token_class = cls;
        out_next.pair_start  = pstart;
        if (last) begin
            if (phase_next != PH_ENDED) begin
                final_st = (phase_next == PH_BODY) ? htok_pkg::ST_OK : htok_pkg::ST_BAD;
            end else begin
                final_st = err_next;
            end
            out_next.done_res    = 1'b1;
            out_next.status      = final_st;
            out_next.body_length = 16'(count_next);
            // back to the start of a new request
            phase_next    = PH_METHOD;
            ver_idx_next  = '0;
            mismatch_next = 1'b0;
            pcr_next      = 1'b0;
            colon_next    = 1'b0;
            err_next      = htok_pkg::ST_PARSING;
            count_next    = '0;
        end else begin
            out_next.done_res    = 1'b0;
            out_next.status      = htok_pkg::ST_PARSING;
            out_next.body_length = '0;
        end
    end

    // Parser state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_METHOD;
            ver_idx_reg   <= '0;
            mismatch_reg  <= 1'b0;
            pcr_reg       <= 1'b0;
            colon_reg     <= 1'b0;
            err_reg       <= htok_pkg::ST_PARSING;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                phase_reg    <= phase_next;
                ver_idx_reg  <= ver_idx_next;
                mismatch_reg <= mismatch_next;
                pcr_reg      <= pcr_next;
                colon_reg    <= colon_next;
                err_reg      <= err_next;
                count_reg    <= count_next;
            end
            if (pop) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload, no reset
    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg <= out_next;
        end
    end

endmodule

>>> src/http_request_tokenizer.sv
// HTTP request tokenizer top level: front classifier, queue, parser back end.
// A byte accepted is written into the queue, then taken by the parser step into the output register.
// Throughput: one byte per cycle while m_ready takes each result; the back end parser step is combinational.
// A stalled result holds in the output register while the queue accepts up to two more bytes.
// Reset (aresetn low, synchronous) empties the queue and output and returns the parser
// to the method phase; the state also returns there after every byte marked last.
module http_request_tokenizer #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  htok_pkg::htok_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output htok_pkg::htok_out_t m_data
);

    htok_pkg::htok_q_status_t q_status;
    htok_pkg::htok_entry_t    push_entry;
    htok_pkg::htok_entry_t    head_entry;
    logic                     push;
    logic                     pop;

    htok_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    htok_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .q_status   (q_status)
    );

    htok_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_entry (head_entry),
        .q_status   (q_status),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    // The back end never takes from an empty queue
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

    // A done result carries a final status
    a_done_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.done_res) |-> (m_data.status != htok_pkg::ST_PARSING))
        else $error("done result with parsing status");

    // Intermediate results report parsing and zero length
    a_not_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.done_res) |->
            (m_data.status == htok_pkg::ST_PARSING && m_data.body_length == '0))
        else $error("intermediate result with final fields");

    // A byte taken from the queue shows up as a result in the next cycle
    a_pop_result: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> m_valid)
        else $error("popped byte produced no result");

endmodule
